/* rtl/fdr_pkg.sv */
// Shared types, constants and helpers for the frame descriptor ring.
package fdr_pkg;

   localparam int RING_DEPTH = 16;
   localparam int LEN_BITS   = 24;

   localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int ADV_W  = PTR_W + 1;
   localparam int CAP_W  = 5;
   localparam int CAPX_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;
   localparam int SLOT_W = 4;
   localparam int IDXC_W = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;
   localparam int FLEN_W = 24;
   localparam int CSR_W  = 24;

   localparam logic [CAP_W-1:0]  CAP_RESET   = CAP_W'(16);
   localparam logic [FLEN_W-1:0] FRAME_RESET = FLEN_W'(1024 * 1024);

   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_POP     = 2'd1,
      OP_RELEASE = 2'd2
   } op_type;

   typedef enum logic {
      CSR_RING_CAPACITY = 1'b0,
      CSR_MAX_FRAME     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [FLEN_W-1:0] base_len;
      logic [FLEN_W-1:0] dep_len;
      logic [63:0]       timestamp;
      logic              keyframe;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [SLOT_W-1:0] slot_out;
      logic [FLEN_W-1:0] base_size_out;
      logic [FLEN_W-1:0] dep_size_out;
      logic [63:0]       timestamp_out;
      logic              keyframe_out;
      logic [31:0]       sequence_out;
      logic [4:0]        occupancy;
      logic [31:0]       dropped_count;
   } rsp_type;

   typedef struct packed {
      logic [LEN_BITS-1:0] base_len;
      logic [LEN_BITS-1:0] dep_len;
      logic [63:0]         timestamp;
      logic                keyframe;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [PTR_W-1:0] waddr;
      entry_type        wdata;
      logic [PTR_W-1:0] raddr;
   } store_ctl_type;

   function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p,
                                                    input logic [CNT_W-1:0] cap);
      logic [ADV_W-1:0] nxt;
      nxt = ADV_W'(p) + ADV_W'(1);
      return (nxt >= ADV_W'(cap)) ? '0 : PTR_W'(nxt);
   endfunction

endpackage

/* rtl/fdr_slot_store.sv */
// Generic RAM: one write port and one read port with registered read data.
module fdr_slot_store #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read returns the old word when the same address is written on that edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/fdr_ctrl.sv */
// Ring control: pointers, occupancy, held slots, counters and result build.
module fdr_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  fdr_pkg::req_type              item,
   input  logic [fdr_pkg::CAP_W-1:0]     ring_capacity,
   input  logic [fdr_pkg::FLEN_W-1:0]    max_frame_bytes,
   input  fdr_pkg::entry_type            rd_entry,
   output fdr_pkg::store_ctl_type        store_ctl,
   output fdr_pkg::rsp_type              rsp
);
   import fdr_pkg::*;

   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [RING_DEPTH-1:0] held_ff, held_in;
   logic [31:0]           seq_ff, seq_in;
   logic [31:0]           drop_ff, drop_in;
   logic                  byp_ff, byp_in;
   entry_type             byp_data_ff;
   entry_type             tail_entry;

   logic [CAPX_W-1:0] capx;
   logic [CNT_W-1:0]  cap;
   logic [31:0]       lim_w;
   logic [31:0]       top_w;
   logic [LEN_BITS-1:0] lim;
   logic [IDXC_W-1:0] rel_idx;

   always_comb begin
      capx = CAPX_W'(ring_capacity);
      if (capx == '0) begin
         capx = CAPX_W'(1);
      end else if (capx > CAPX_W'(RING_DEPTH)) begin
         capx = CAPX_W'(RING_DEPTH);
      end
      cap = CNT_W'(capx);

      lim_w = (max_frame_bytes == '0) ? 32'(FRAME_RESET) : 32'(max_frame_bytes);
      top_w = (32'd1 << LEN_BITS) - 32'd1;
      if (lim_w > top_w) begin
         lim_w = top_w;
      end
      lim = LEN_BITS'(lim_w);
   end

   // tail word from the store, or the word written to that slot on the last edge
   assign tail_entry = byp_ff ? byp_data_ff : rd_entry;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      held_in  = held_ff;
      seq_in   = seq_ff;
      drop_in  = drop_ff;
      rel_idx  = IDXC_W'(item.slot_index);

      store_ctl.wr_en = 1'b0;
      store_ctl.waddr = head_ff;
      store_ctl.wdata.base_len  = (32'(item.base_len) > lim_w) ? lim : LEN_BITS'(item.base_len);
      store_ctl.wdata.dep_len   = (32'(item.dep_len) > lim_w) ? lim : LEN_BITS'(item.dep_len);
      store_ctl.wdata.timestamp = item.timestamp;
      store_ctl.wdata.keyframe  = item.keyframe;

      rsp = '0;

      if (item_valid) begin
         case (item.opcode)
            OP_PUSH: begin
               if (held_ff[head_ff]) begin
                  drop_in = drop_ff + 32'd1;
               end else begin
                  // full ring: the oldest word is overwritten
                  if (count_ff >= cap) begin
                     tail_in  = ptr_advance(tail_ff, cap);
                     count_in = count_ff - CNT_W'(1);
                     drop_in  = drop_ff + 32'd1;
                  end
                  store_ctl.wr_en = 1'b1;
                  head_in  = ptr_advance(head_ff, cap);
                  count_in = count_in + CNT_W'(1);
                  rsp.ok   = 1'b1;
               end
            end
            OP_POP: begin
               if (count_ff != '0) begin
                  held_in[tail_ff]  = 1'b1;
                  rsp.ok            = 1'b1;
                  rsp.slot_out      = SLOT_W'(tail_ff);
                  rsp.base_size_out = FLEN_W'(tail_entry.base_len);
                  rsp.dep_size_out  = FLEN_W'(tail_entry.dep_len);
                  rsp.timestamp_out = tail_entry.timestamp;
                  rsp.keyframe_out  = tail_entry.keyframe;
                  rsp.sequence_out  = seq_ff;
                  seq_in   = seq_ff + 32'd1;
                  tail_in  = ptr_advance(tail_ff, cap);
                  count_in = count_ff - CNT_W'(1);
               end
            end
            OP_RELEASE: begin
               for (int i = 0; i < RING_DEPTH; i++) begin
                  if (rel_idx < IDXC_W'(cap) && rel_idx == IDXC_W'(i)) begin
                     held_in[i] = 1'b0;
                  end
               end
               rsp.ok = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // store read is registered, so the next tail slot is fetched ahead of use
      store_ctl.raddr = tail_in;
      byp_in          = store_ctl.wr_en && (store_ctl.waddr == tail_in);

      rsp.occupancy     = 5'(count_in);
      rsp.dropped_count = drop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         held_ff  <= '0;
         seq_ff   <= '0;
         drop_ff  <= '0;
         byp_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         held_ff  <= held_in;
         seq_ff   <= seq_in;
         drop_ff  <= drop_in;
         byp_ff   <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= store_ctl.wdata;
   end

endmodule

/* rtl/frame_descriptor_ring.sv */
// Frame descriptor ring top level: command register, config, result register.
//
// One command word (push, pop or release) is taken on any cycle where start
// is high and busy is low; busy is only high during reset, so a new word can
// be issued every cycle. The result word is on rsp_data with rsp_valid high
// for exactly one cycle, after the command register and the result register;
// the receiver must take it then. The ring update logic between those two
// registers is combinational. Configuration writes land on the next edge and
// must only be issued while no command is in flight; capacity should change
// only with the ring empty.
module frame_descriptor_ring (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  fdr_pkg::req_type             req_data,
   output logic                         rsp_valid,
   output fdr_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [fdr_pkg::CSR_W-1:0]    csr_wdata
);
   import fdr_pkg::*;

   logic              req_valid_ff, req_valid_in;
   req_type           req_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic [CAP_W-1:0]  ring_capacity_ff;
   logic [FLEN_W-1:0] max_frame_ff;

   store_ctl_type     store_ctl;
   entry_type         rd_entry;

   assign busy         = reset;
   assign req_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         ring_capacity_ff <= CAP_RESET;
         max_frame_ff     <= FRAME_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_RING_CAPACITY: ring_capacity_ff <= CAP_W'(csr_wdata);
               CSR_MAX_FRAME:     max_frame_ff     <= FLEN_W'(csr_wdata);
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   fdr_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (req_valid_ff),
      .item            (req_ff),
      .ring_capacity   (ring_capacity_ff),
      .max_frame_bytes (max_frame_ff),
      .rd_entry        (rd_entry),
      .store_ctl       (store_ctl),
      .rsp             (rsp_in)
   );

   fdr_slot_store #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (RING_DEPTH)
   ) u_store (
      .clock (clock),
      .wr_en (store_ctl.wr_en),
      .waddr (store_ctl.waddr),
      .wdata (store_ctl.wdata),
      .raddr (store_ctl.raddr),
      .rdata (rd_entry)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the frame descriptor ring: directed and random command words.
`timescale 1ns / 1ps

module testbench;
   import fdr_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         QUIET_LIMIT = 2000;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                start     = 1'b0;
   logic                busy;
   req_type             req_data  = '0;
   logic                rsp_valid;
   rsp_type             rsp_data;
   logic                csr_we    = 1'b0;
   logic                csr_index = CSR_RING_CAPACITY;
   logic [CSR_W-1:0]    csr_wdata = '0;

   frame_descriptor_ring i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // ring state as the block should hold it
   logic [CAP_W-1:0]  cap_setting   = CAP_RESET;
   logic [FLEN_W-1:0] frame_setting = FRAME_RESET;
   logic [3:0]        ring_head     = '0;
   logic [3:0]        ring_tail     = '0;
   logic [4:0]        ring_fill     = '0;
   logic              slot_busy  [16] = '{default: 1'b0};
   logic [FLEN_W-1:0] slot_base  [16] = '{default: '0};
   logic [FLEN_W-1:0] slot_dep   [16] = '{default: '0};
   logic [63:0]       slot_stamp [16] = '{default: '0};
   logic              slot_key   [16] = '{default: 1'b0};
   logic [31:0]       pop_seq       = '0;
   logic [31:0]       frames_dropped = '0;
   logic [3:0]        last_slot     = '0;

   rsp_type pending_results[$];
   int      mismatch_count = 0;
   int      words_sent     = 0;
   int      results_seen   = 0;
   int      csr_writes     = 0;
   int      frames_popped  = 0;
   int      gap_pct        = 23;
   int      quiet_cycles   = 0;

   function automatic logic [4:0] ring_size();
      if (cap_setting == '0)
         return 5'd1;
      if (cap_setting > 5'(RING_DEPTH))
         return 5'(RING_DEPTH);
      return cap_setting;
   endfunction

   function automatic logic [FLEN_W-1:0] frame_limit();
      return (frame_setting == '0) ? FRAME_RESET : frame_setting;
   endfunction

   function automatic logic [3:0] next_slot(logic [3:0] p, logic [4:0] cap);
      logic [4:0] n;
      n = {1'b0, p} + 5'd1;
      return (n >= cap) ? 4'd0 : n[3:0];
   endfunction

   function automatic logic [FLEN_W-1:0] clamp_len(logic [FLEN_W-1:0] v);
      return (v > frame_limit()) ? frame_limit() : v;
   endfunction

   // updates the ring state for one command word and returns its result
   function automatic rsp_type apply_descriptor_op(req_type w);
      rsp_type    r;
      logic [4:0] cap;
      r   = '0;
      cap = ring_size();
      case (w.opcode)
         OP_PUSH: begin
            if (slot_busy[ring_head]) begin
               frames_dropped++;
            end else begin
               // full ring: oldest entry goes
               if (ring_fill >= cap) begin
                  ring_tail = next_slot(ring_tail, cap);
                  ring_fill--;
                  frames_dropped++;
               end
               slot_base[ring_head]  = clamp_len(w.base_len);
               slot_dep[ring_head]   = clamp_len(w.dep_len);
               slot_stamp[ring_head] = w.timestamp;
               slot_key[ring_head]   = w.keyframe;
               ring_head = next_slot(ring_head, cap);
               ring_fill++;
               r.ok = 1'b1;
            end
         end
         OP_POP: begin
            if (ring_fill != '0) begin
               slot_busy[ring_tail] = 1'b1;
               r.ok            = 1'b1;
               r.slot_out      = ring_tail;
               r.base_size_out = slot_base[ring_tail];
               r.dep_size_out  = slot_dep[ring_tail];
               r.timestamp_out = slot_stamp[ring_tail];
               r.keyframe_out  = slot_key[ring_tail];
               r.sequence_out  = pop_seq;
               last_slot = ring_tail;
               pop_seq++;
               frames_popped++;
               ring_tail = next_slot(ring_tail, cap);
               ring_fill--;
            end
         end
         OP_RELEASE: begin
            if ({1'b0, w.slot_index} < cap)
               slot_busy[w.slot_index] = 1'b0;
            r.ok = 1'b1;
         end
         default: ;
      endcase
      r.occupancy     = ring_fill;
      r.dropped_count = frames_dropped;
      return r;
   endfunction

   function automatic logic [FLEN_W-1:0] rand_len();
      case ($urandom_range(3))
         0:       return FLEN_W'($urandom);
         1:       return FLEN_W'($urandom_range(frame_limit()));
         2:       return frame_limit() - 24'd1 + FLEN_W'($urandom_range(2));
         default: return FLEN_W'($urandom_range(255));
      endcase
   endfunction

   function automatic req_type ctl_word(logic [1:0] op, logic [3:0] idx);
      req_type w;
      w.opcode     = op;
      w.base_len   = FLEN_W'($urandom);
      w.dep_len    = FLEN_W'($urandom);
      w.timestamp  = {$urandom, $urandom};
      w.keyframe   = 1'($urandom);
      w.slot_index = idx;
      return w;
   endfunction

   function automatic req_type push_word(logic [FLEN_W-1:0] base, logic [FLEN_W-1:0] dep,
                                         logic [63:0] stamp, logic key);
      req_type w;
      w           = ctl_word(OP_PUSH, 4'($urandom));
      w.base_len  = base;
      w.dep_len   = dep;
      w.timestamp = stamp;
      w.keyframe  = key;
      return w;
   endfunction

   function automatic req_type rand_word();
      req_type w;
      int      roll;
      int      pick;
      logic    found;
      roll = $urandom_range(99);
      if (roll < 42)
         w = ctl_word(OP_PUSH, 4'($urandom));
      else if (roll < 77)
         w = ctl_word(OP_POP, 4'($urandom));
      else if (roll < 95)
         w = ctl_word(OP_RELEASE, 4'($urandom));
      else
         w = ctl_word(OP_UNUSED, 4'($urandom));
      w.base_len = rand_len();
      w.dep_len  = rand_len();
      // most releases go to a slot the consumer actually holds
      if (w.opcode == OP_RELEASE && $urandom_range(9) < 7) begin
         pick  = $urandom_range(15);
         found = 1'b0;
         for (int k = 0; k < 16; k++) begin
            if (!found && slot_busy[4'(pick + k)]) begin
               w.slot_index = 4'(pick + k);
               found = 1'b1;
            end
         end
      end
      return w;
   endfunction

   task automatic send_word(req_type w);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy !== 1'b0);
      pending_results.push_back(apply_descriptor_op(w));
      words_sent++;
   endtask

   // stop issuing and wait for every outstanding result
   task automatic settle();
      start <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_RING_CAPACITY)
         cap_setting = value[CAP_W-1:0];
      else
         frame_setting = value[FLEN_W-1:0];
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result word with no command outstanding");
            mismatch_count++;
         end else begin
            rsp_type want;
            want = pending_results.pop_front();
            check_field("rsp_valid", 1, rsp_valid);
            check_field("ok", want.ok, rsp_data.ok);
            check_field("slot_out", want.slot_out, rsp_data.slot_out);
            check_field("base_size_out", want.base_size_out, rsp_data.base_size_out);
            check_field("dep_size_out", want.dep_size_out, rsp_data.dep_size_out);
            check_field("timestamp_out", want.timestamp_out, rsp_data.timestamp_out);
            check_field("keyframe_out", want.keyframe_out, rsp_data.keyframe_out);
            check_field("sequence_out", want.sequence_out, rsp_data.sequence_out);
            check_field("occupancy", want.occupancy, rsp_data.occupancy);
            check_field("dropped_count", want.dropped_count, rsp_data.dropped_count);
         end
      end
   end

   // ends a hung run: nothing taken in and nothing coming out
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_empty_ring();
      send_word(ctl_word(OP_POP, 4'd0));
      send_word(ctl_word(OP_UNUSED, 4'd15));
   endtask

   // writes every slot once, then one more push on a full ring
   task automatic test_fill_and_overflow();
      logic [FLEN_W-1:0] lens[4];
      logic [63:0]       stamp;
      lens = '{24'd0, 24'hFFFFFF, frame_limit(), frame_limit() + 24'd1};
      for (int i = 0; i < 16; i++) begin
         stamp = (i == 0) ? 64'd0 : (i == 1) ? '1 : {$urandom, $urandom};
         send_word(push_word(lens[i % 4], lens[(i + 2) % 4], stamp, 1'(i)));
      end
      send_word(push_word(24'h0ABCDE, 24'h000001, {$urandom, $urandom}, 1'b1));
   endtask

   // pop leaves the head slot held, so the next push is refused
   task automatic test_held_head();
      send_word(ctl_word(OP_POP, 4'd0));
      send_word(push_word(24'd100, 24'd200, {$urandom, $urandom}, 1'b0));
      send_word(ctl_word(OP_RELEASE, last_slot));
   endtask

   task automatic test_config_extremes();
      settle();
      // zero capacity acts as one, zero limit as the default; ring is not empty here
      write_csr(CSR_RING_CAPACITY, 24'd0);
      write_csr(CSR_MAX_FRAME, 24'd0);
      send_word(push_word(24'hFFFFFF, 24'h100001, '1, 1'b1));
      send_word(ctl_word(OP_RELEASE, 4'd15));
      settle();
      // oversize capacity value, upper data bits set
      write_csr(CSR_RING_CAPACITY, {19'h5A5A5, 5'h1F});
      write_csr(CSR_MAX_FRAME, 24'd1);
      send_word(push_word(24'hFFFFFF, 24'd0, {$urandom, $urandom}, 1'b0));
      settle();
      write_csr(CSR_MAX_FRAME, 24'hFFFFFF);
      send_word(push_word(24'hFFFFFF, 24'hFFFFFE, {$urandom, $urandom}, 1'b1));
      send_word(ctl_word(OP_POP, 4'd0));
   endtask

   task automatic flush_ring();
      settle();
      write_csr(CSR_RING_CAPACITY, 24'd16);
      while (ring_fill != '0)
         send_word(ctl_word(OP_POP, 4'($urandom)));
      for (int s = 0; s < 16; s++)
         if (slot_busy[s])
            send_word(ctl_word(OP_RELEASE, 4'(s)));
      settle();
   endtask

   task automatic test_random_traffic();
      logic [4:0]        cap;
      logic [FLEN_W-1:0] lim;
      for (int phase = 0; phase < 12; phase++) begin
         gap_pct = (phase == 4) ? 0 : 23;
         // most phases start empty; the rest resize a loaded ring
         if ($urandom_range(2) != 0)
            flush_ring();
         else
            settle();
         case ($urandom_range(5))
            0:       cap = 5'd0;
            1:       cap = 5'd1;
            2:       cap = 5'd16;
            3:       cap = 5'($urandom_range(31, 17));
            default: cap = 5'($urandom_range(15, 2));
         endcase
         case ($urandom_range(5))
            0:       lim = 24'd0;
            1:       lim = 24'd1;
            2:       lim = 24'hFFFFFF;
            3:       lim = 24'($urandom_range(4096, 1));
            default: lim = 24'($urandom);
         endcase
         write_csr(CSR_RING_CAPACITY, {19'($urandom), cap});
         write_csr(CSR_MAX_FRAME, lim);
         for (int n = 0; n < 100; n++)
            send_word(rand_word());
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_ring();
      test_fill_and_overflow();
      test_held_head();
      test_config_extremes();
      test_random_traffic();
      settle();
      repeat (4) @(posedge clock);
      $display("%0d command words, %0d results checked, %0d register writes",
               words_sent, results_seen, csr_writes);
      $display("%0d frames popped, %0d frames dropped", frames_popped, frames_dropped);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* files.f */
rtl/fdr_pkg.sv
rtl/fdr_slot_store.sv
rtl/fdr_ctrl.sv
rtl/frame_descriptor_ring.sv
tb/sv/testbench.sv
